>>> hdl/ebalu_pkg.sv
// Shared types and constants of the eight-bit accumulator ALU.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ebalu_pkg;

	// Operation codes carried in req_type.
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_ADC = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_SBC = 4'd3;
	localparam logic [3:0] OP_AND = 4'd4;
	localparam logic [3:0] OP_XOR = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_CP  = 4'd7;
	localparam logic [3:0] OP_INC = 4'd8;
	localparam logic [3:0] OP_DEC = 4'd9;
	localparam logic [3:0] OP_DAA = 4'd10;
	localparam logic [3:0] OP_CPL = 4'd11;

	// Decimal adjust constants.
	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [3:0] NIBBLE_MAX   = 4'hF;
	localparam logic [7:0] BYTE_ONES    = 8'hFF;

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [3:0] {
		CL_ADD,
		CL_SUB,
		CL_AND,
		CL_XOR,
		CL_OR,
		CL_INC,
		CL_DEC,
		CL_DAA,
		CL_CPL,
		CL_NOP
	} op_class_t;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] operand;
	} req_t;

	typedef struct packed {
		logic [7:0] acc_out;
		logic [7:0] result_byte;
		logic       zero_flag;
		logic       subtract_flag;
		logic       half_carry_flag;
		logic       carry_flag;
	} rsp_t;

	// A classified operation as it waits in the queue.
	typedef struct packed {
		op_class_t  cls;
		logic       with_carry;
		logic       write_acc;
		logic [7:0] operand;
	} q_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

endpackage

>>> hdl/ebalu_front.sv
// Front end: accepts requests and classifies the operation code.
// Depends on ebalu_pkg; feeds the queue in ebalu_queue.
module ebalu_front import ebalu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_t      req,
	input  q_status_t q_status,
	output logic      push,
	output q_item_t   push_item
);

	logic    valid_s1;
	q_item_t item_s1;
	q_item_t item_dec;
	logic    take_in;

	always_comb begin
		item_dec            = '0;
		item_dec.operand    = req.operand;
		item_dec.with_carry = 1'b0;
		item_dec.write_acc  = 1'b1;
		unique case (req.req_type) inside
			OP_ADD, OP_ADC: begin
				item_dec.cls        = CL_ADD;
				item_dec.with_carry = (req.req_type == OP_ADC);
			end
			OP_SUB, OP_SBC, OP_CP: begin
				item_dec.cls        = CL_SUB;
				item_dec.with_carry = (req.req_type == OP_SBC);
				item_dec.write_acc  = (req.req_type != OP_CP);
			end
			OP_AND: item_dec.cls = CL_AND;
			OP_XOR: item_dec.cls = CL_XOR;
			OP_OR:  item_dec.cls = CL_OR;
			OP_INC: item_dec.cls = CL_INC;
			OP_DEC: item_dec.cls = CL_DEC;
			OP_DAA: item_dec.cls = CL_DAA;
			OP_CPL: item_dec.cls = CL_CPL;
			default: item_dec.cls = CL_NOP;
		endcase
	end

	// The stage empties whenever the queue has room, so a new transfer can
	// follow in every cycle.
	assign push      = valid_s1 && !q_status.full;
	assign req_stall = valid_s1 && q_status.full;
	assign take_in   = req_valid && !req_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item_dec;
		end
	end

endmodule

>>> hdl/ebalu_queue.sv
// Short queue of classified operations between front and back.
// Depends on ebalu_pkg.
module ebalu_queue import ebalu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_item_t   push_item,
	input  logic      pop,
	output q_item_t   head,
	output q_status_t status
);

	q_item_t           entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_W'(1);
		end
		return r;
	endfunction

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("queue pushed while full");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
		else $error("queue count did not follow a push");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

>>> hdl/ebalu_back.sv
// Back end: executes queued operations against the accumulator and flags,
// and holds each result in an output register. Depends on ebalu_pkg.
module ebalu_back import ebalu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_item_t   head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_t      rsp
);

	logic [7:0] acc_q;
	flags_t     flags_q;
	logic       out_valid_q;
	rsp_t       out_q;

	logic [7:0] acc_nx;
	logic [7:0] wb_nx;
	flags_t     flags_nx;
	logic       cin;
	logic [8:0] sum;
	logic [4:0] sum_lo;
	logic [8:0] diff;
	logic [4:0] diff_lo;
	logic [7:0] logic_res;
	logic [7:0] daa_adj;
	logic       daa_c;
	logic [7:0] daa_res;
	logic [7:0] inc_res;
	logic [7:0] dec_res;

	assign pop = !q_status.empty && (!out_valid_q || !rsp_stall);

	always_comb begin
		cin     = head.with_carry & flags_q.c;
		sum     = {1'b0, acc_q} + {1'b0, head.operand} + 9'(cin);
		sum_lo  = {1'b0, acc_q[3:0]} + {1'b0, head.operand[3:0]} + 5'(cin);
		diff    = {1'b0, acc_q} - {1'b0, head.operand} - 9'(cin);
		diff_lo = {1'b0, acc_q[3:0]} - {1'b0, head.operand[3:0]} - 5'(cin);
		inc_res = head.operand + 8'd1;
		dec_res = head.operand - 8'd1;

		case (head.cls)
			CL_AND:  logic_res = acc_q & head.operand;
			CL_XOR:  logic_res = acc_q ^ head.operand;
			default: logic_res = acc_q | head.operand;
		endcase

		// Decimal adjust: upward after an addition, downward after a subtraction.
		daa_adj = '0;
		daa_c   = flags_q.c;
		if (!flags_q.n) begin
			if (flags_q.c || (acc_q > DAA_HI_LIMIT)) begin
				daa_adj = daa_adj | DAA_HI_ADJ;
				daa_c   = 1'b1;
			end
			if (flags_q.h || (acc_q[3:0] > DAA_LO_LIMIT)) begin
				daa_adj = daa_adj | DAA_LO_ADJ;
			end
			daa_res = acc_q + daa_adj;
		end else begin
			if (flags_q.c) begin
				daa_adj = daa_adj | DAA_HI_ADJ;
			end
			if (flags_q.h) begin
				daa_adj = daa_adj | DAA_LO_ADJ;
			end
			daa_res = acc_q - daa_adj;
		end

		acc_nx   = acc_q;
		flags_nx = flags_q;
		case (head.cls)
			CL_ADD: begin
				acc_nx   = sum[7:0];
				flags_nx = '{z: (sum[7:0] == '0), n: 1'b0, h: sum_lo[4], c: sum[8]};
			end
			CL_SUB: begin
				if (head.write_acc) begin
					acc_nx = diff[7:0];
				end
				flags_nx = '{z: (diff[7:0] == '0), n: 1'b1, h: diff_lo[4], c: diff[8]};
			end
			CL_AND, CL_XOR, CL_OR: begin
				acc_nx   = logic_res;
				flags_nx = '{z: (logic_res == '0), n: 1'b0,
					h: (head.cls == CL_AND), c: 1'b0};
			end
			CL_INC: begin
				flags_nx = '{z: (inc_res == '0), n: 1'b0,
					h: (head.operand[3:0] == NIBBLE_MAX), c: flags_q.c};
			end
			CL_DEC: begin
				flags_nx = '{z: (dec_res == '0), n: 1'b1,
					h: (head.operand[3:0] == 4'h0), c: flags_q.c};
			end
			CL_DAA: begin
				acc_nx   = daa_res;
				flags_nx = '{z: (daa_res == '0), n: flags_q.n, h: 1'b0, c: daa_c};
			end
			CL_CPL: begin
				acc_nx   = acc_q ^ BYTE_ONES;
				flags_nx = '{z: flags_q.z, n: 1'b1, h: 1'b1, c: flags_q.c};
			end
			default: begin
				acc_nx   = acc_q;
				flags_nx = flags_q;
			end
		endcase

		case (head.cls)
			CL_INC:  wb_nx = inc_res;
			CL_DEC:  wb_nx = dec_res;
			default: wb_nx = acc_nx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q       <= acc_nx;
				flags_q     <= flags_nx;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.acc_out         <= acc_nx;
			out_q.result_byte     <= wb_nx;
			out_q.zero_flag       <= flags_nx.z;
			out_q.subtract_flag   <= flags_nx.n;
			out_q.half_carry_flag <= flags_nx.h;
			out_q.carry_flag      <= flags_nx.c;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && (out_q.acc_out == acc_q)))
		else $error("result register does not match the accumulator");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |-> !pop)
		else $error("stalled result overwritten");

	a_acc_held: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(acc_q) && $stable(flags_q))
		else $error("accumulator changed without an operation");

endmodule

>>> hdl/eight_bit_alu_with_flags_top.sv
// Top level of the eight-bit accumulator ALU with flags.
// Depends on ebalu_pkg, ebalu_front, ebalu_queue and ebalu_back.
//
//   Channel  Handshake             Payload  Carries
//   req      req_valid/req_stall   req_t    req_type, operand
//   rsp      rsp_valid/rsp_stall   rsp_t    acc_out, result_byte, Z, N, H, C flags
//
// One operation per cycle sustained while rsp_stall stays low; a request passes from
// the front stage register through the queue into execute and the result register.
// The accumulator and flag update loops from acc_q and flags_q back into them in the back end.
// arst_n clears the accumulator, the flags and all valid state.
// A stall on rsp fills the queue first; req_stall rises only once it is full.
module eight_bit_alu_with_flags_top import ebalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	q_status_t q_status;
	logic      push;
	q_item_t   push_item;
	logic      pop;
	q_item_t   head;

	ebalu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	ebalu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ebalu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the eight-bit accumulator ALU with flags.
// Depends on ebalu_pkg and eight_bit_alu_with_flags_top; it keeps its own ALU
// model and checks every result transfer against it.
module tb_top import ebalu_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Codes outside the defined operation set; the block treats them as no-ops.
	localparam logic [3:0] OP_UNUSED_LO = 4'd12;
	localparam logic [3:0] OP_UNUSED_HI = 4'd15;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t pending_requests[$];
	rsp_t expected_results[$];
	logic [7:0] acc_model = '0;
	flags_t flags_model = '0;

	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 87;
	bit hold_armed = 1'b0;
	int hold_count = 0;
	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int directed_count = 0;

	eight_bit_alu_with_flags_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Advances the accumulator and flag model by one operation and returns
	// the result the block should report for it.
	function automatic rsp_t predict_alu(input req_t r);
		logic [8:0] wide;
		logic [4:0] nib;
		logic [7:0] a;
		logic [7:0] v;
		logic [7:0] wb;
		logic [7:0] adj;
		logic cin;
		flags_t f;
		rsp_t o;
		a = acc_model;
		f = flags_model;
		v = r.operand;
		cin = (r.req_type == OP_ADC || r.req_type == OP_SBC) ? flags_model.c : 1'b0;
		case (r.req_type)
			OP_ADD, OP_ADC: begin
				wide = {1'b0, a} + {1'b0, v} + {8'd0, cin};
				nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
				a = wide[7:0];
				f.z = (a == 8'd0);
				f.n = 1'b0;
				f.h = nib[4];
				f.c = wide[8];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				// Bit 8 of the nine-bit difference is the borrow out of bit 7.
				wide = {1'b0, a} - {1'b0, v} - {8'd0, cin};
				nib = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
				f.z = (wide[7:0] == 8'd0);
				f.n = 1'b1;
				f.h = nib[4];
				f.c = wide[8];
				if (r.req_type != OP_CP)
					a = wide[7:0];
			end
			OP_AND: begin
				a = a & v;
				f.z = (a == 8'd0);
				f.n = 1'b0;
				f.h = 1'b1;
				f.c = 1'b0;
			end
			OP_XOR, OP_OR: begin
				a = (r.req_type == OP_XOR) ? (a ^ v) : (a | v);
				f.z = (a == 8'd0);
				f.n = 1'b0;
				f.h = 1'b0;
				f.c = 1'b0;
			end
			OP_DAA: begin
				if (!f.n) begin
					adj = 8'd0;
					if (f.c || a > DAA_HI_LIMIT) begin
						adj = adj | DAA_HI_ADJ;
						f.c = 1'b1;
					end
					if (f.h || a[3:0] > DAA_LO_LIMIT)
						adj = adj | DAA_LO_ADJ;
					a = a + adj;
				end else begin
					if (f.c)
						a = a - DAA_HI_ADJ;
					if (f.h)
						a = a - DAA_LO_ADJ;
				end
				f.z = (a == 8'd0);
				f.h = 1'b0;
			end
			OP_CPL: begin
				a = a ^ BYTE_ONES;
				f.n = 1'b1;
				f.h = 1'b1;
			end
			default: ;
		endcase
		wb = a;
		if (r.req_type == OP_INC) begin
			wb = v + 8'd1;
			f.z = (wb == 8'd0);
			f.n = 1'b0;
			f.h = (v[3:0] == NIBBLE_MAX);
		end else if (r.req_type == OP_DEC) begin
			wb = v - 8'd1;
			f.z = (wb == 8'd0);
			f.n = 1'b1;
			f.h = (v[3:0] == 4'd0);
		end
		acc_model = a;
		flags_model = f;
		o.acc_out = a;
		o.result_byte = wb;
		o.zero_flag = f.z;
		o.subtract_flag = f.n;
		o.half_carry_flag = f.h;
		o.carry_flag = f.c;
		return o;
	endfunction

	task automatic add_request(input logic [3:0] op, input logic [7:0] operand);
		req_t r;
		r.req_type = op;
		r.operand = operand;
		pending_requests.push_back(r);
	endtask

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return BYTE_ONES;
			2: return 8'h0F;
			3: return 8'hF0;
			4: return 8'h80;
			5: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Most random traffic is ordinary operations; a share is BCD arithmetic
	// followed by a decimal adjust so that the adjust sees realistic flags.
	task automatic queue_random(input int count);
		int n;
		logic [3:0] op;
		logic [7:0] bcd;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 20) begin
				bcd = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
				op = 4'($urandom_range(OP_ADD, OP_SBC));
				add_request(op, bcd);
				add_request(OP_DAA, pick_operand());
				n += 2;
			end else begin
				if ($urandom_range(0, 99) < 5)
					op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
				else
					op = 4'($urandom_range(OP_ADD, OP_CPL));
				add_request(op, pick_operand());
				n++;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			error_count++;
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
	endtask

	// Request driver: the model advances on each accepted transfer, so its
	// state follows the order in which the block takes requests.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_results.push_back(predict_alu(req));
				requests_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= pending_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("Result transfer with nothing expected: %p", rsp);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("acc_out", exp_r.acc_out, rsp.acc_out);
					check_field("result_byte", exp_r.result_byte, rsp.result_byte);
					check_field("zero_flag", exp_r.zero_flag, rsp.zero_flag);
					check_field("subtract_flag", exp_r.subtract_flag, rsp.subtract_flag);
					check_field("half_carry_flag", exp_r.half_carry_flag,
						rsp.half_carry_flag);
					check_field("carry_flag", exp_r.carry_flag, rsp.carry_flag);
					results_checked++;
				end
			end
			// A long hold-off lets the block fill up and stall its input.
			if (hold_armed && hold_count < HOLD_CYCLES) begin
				rsp_stall <= 1'b1;
				hold_count++;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		@(negedge clk);
		// Directed opening: flag extremes of each operation, then decimal adjust
		// after addition and after subtraction, complement and the unused codes.
		add_request(OP_ADD, BYTE_ONES);
		add_request(OP_ADC, 8'h01);
		add_request(OP_ADC, BYTE_ONES);
		add_request(OP_SUB, 8'h00);
		add_request(OP_SBC, BYTE_ONES);
		add_request(OP_CP, 8'h01);
		add_request(OP_AND, BYTE_ONES);
		add_request(OP_AND, 8'h00);
		add_request(OP_XOR, BYTE_ONES);
		add_request(OP_OR, 8'h0F);
		add_request(OP_INC, BYTE_ONES);
		add_request(OP_INC, 8'h0F);
		add_request(OP_DEC, 8'h00);
		add_request(OP_DEC, 8'h10);
		add_request(OP_ADD, 8'h09);
		add_request(OP_DAA, 8'hA5);
		add_request(OP_ADD, 8'h99);
		add_request(OP_DAA, 8'h00);
		add_request(OP_SUB, 8'h18);
		add_request(OP_DAA, BYTE_ONES);
		add_request(OP_CPL, 8'h3C);
		add_request(OP_UNUSED_LO, 8'hAA);
		add_request(OP_UNUSED_HI, 8'h55);
		add_request(OP_CPL, 8'h00);
		add_request(OP_DAA, 8'h00);
		directed_count = pending_requests.size();
		queue_random(150);
		wait_drained();

		send_idle_pct = 87;
		recv_idle_pct = 15;
		queue_random(150);
		wait_drained();

		// No idling on either side, apart from one long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(200);
		hold_armed = 1'b1;
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d requests (%0d directed) and checked %0d results,",
			requests_sent, directed_count, results_checked);
		$display("under sender-heavy, receiver-heavy and back-to-back traffic with a long hold-off.");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
hdl/ebalu_pkg.sv
hdl/ebalu_front.sv
hdl/ebalu_queue.sv
hdl/ebalu_back.sv
hdl/eight_bit_alu_with_flags_top.sv
test/tb_top.sv
